FILE: rtl/ccr_pkg.sv
// Shared types, constants and glyph tables of the clock digit column renderer.
`default_nettype none

package ccr_pkg;

    localparam int BIN_W      = 16;
    localparam int BCD_DIGITS = 5;

    typedef logic [3:0] t_digit;
    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic done;
        t_bcd digits;
    } t_bcd_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    localparam t_digit     DIGIT_BLANK = 4'd10;
    localparam logic [7:0] LAST_SAME   = 8'd255;
    localparam logic [7:0] PLACE_MAX   = 8'd5;
    localparam logic [2:0] BIG_PLACES  = 3'd4;
    localparam logic [2:0] BIG_TOP     = 3'd3;
    localparam logic [2:0] BIG_W_M1    = 3'd4;
    localparam logic [2:0] SMALL_W_M1  = 3'd2;

    localparam logic [7:0] BIG_GLYPH [0:49] = '{
        8'h7E, 8'hFF, 8'h81, 8'hFF, 8'h7E,
        8'h00, 8'h04, 8'hFE, 8'hFF, 8'h00,
        8'hC2, 8'hE1, 8'hB1, 8'h9F, 8'h8E,
        8'h49, 8'h8D, 8'h8F, 8'hFB, 8'h71,
        8'h38, 8'h24, 8'hFE, 8'hFF, 8'h20,
        8'h4F, 8'h8F, 8'h89, 8'hF9, 8'h71,
        8'h7E, 8'hFF, 8'h89, 8'hF9, 8'h70,
        8'h01, 8'hF1, 8'hF9, 8'h0F, 8'h07,
        8'h76, 8'hFF, 8'h89, 8'hFF, 8'h76,
        8'h0E, 8'h9F, 8'h91, 8'hFF, 8'h7E
    };

    localparam logic [7:0] SMALL_GLYPH [0:29] = '{
        8'hF8, 8'h88, 8'hF8,
        8'h10, 8'hF8, 8'h00,
        8'hE8, 8'hA8, 8'hB8,
        8'h88, 8'hA8, 8'hF8,
        8'h70, 8'h40, 8'hF8,
        8'hB8, 8'hA8, 8'hE8,
        8'hF8, 8'hA8, 8'hE8,
        8'h08, 8'h08, 8'hF8,
        8'hF8, 8'hA8, 8'hF8,
        8'hB8, 8'hA8, 8'hF8
    };

    function automatic logic [7:0] big_col(input t_digit d, input logic [2:0] j);
        logic [5:0] idx;
        idx = 6'(d) * 6'd5 + 6'(j);
        if (d > 4'd9) return 8'h00;
        return BIG_GLYPH[idx];
    endfunction

    function automatic logic [7:0] small_col(input t_digit d, input logic [2:0] j);
        logic [4:0] idx;
        idx = 5'(d) * 5'd3 + 5'(j);
        if (d > 4'd9) return 8'h00;
        return SMALL_GLYPH[idx];
    endfunction

    // First strip column of each digit place.
    function automatic logic [4:0] place_start(input logic [2:0] p);
        logic [4:0] s;
        case (p)
            3'd0:    s = 5'd0;
            3'd1:    s = 5'd6;
            3'd2:    s = 5'd13;
            3'd3:    s = 5'd19;
            3'd4:    s = 5'd25;
            default: s = 5'd29;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ccr_bcd.sv
// Iterative binary to BCD converter: one add-3 and shift step per cycle.
`default_nettype none

module ccr_bcd (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ccr_pkg::BIN_W-1:0] i_number,
    output ccr_pkg::t_bcd_rsp              o_rsp
);
    import ccr_pkg::*;

    localparam int SR_W = BCD_DIGITS * 4 + BIN_W;

    logic [SR_W-1:0] r_sr;
    logic [SR_W-1:0] n_sr;
    logic [3:0]      r_cnt;
    logic            r_busy;
    logic            r_done;

    // Correct every BCD digit that would overflow on the next doubling.
    always_comb begin
        n_sr = r_sr;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_sr[BIN_W + 4*i +: 4] >= 4'd5) begin
                n_sr[BIN_W + 4*i +: 4] = r_sr[BIN_W + 4*i +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(BIN_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sr <= {{(BCD_DIGITS*4){1'b0}}, i_number};
        end else if (r_busy) begin
            r_sr <= {n_sr[SR_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.digits = r_sr[SR_W-1:BIN_W];

endmodule

`default_nettype wire

FILE: rtl/clock_digit_column_renderer.sv
// Top level: request decode, column sequencer and registered column output.
// A number request first passes through the shift-add BCD converter, then emits one
// column per cycle while the output is not stalled; a blank request skips conversion.
// N, the column count of a request, is up to 26; a request with a bad range is
// accepted but emits no columns.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
`default_nettype none

module clock_digit_column_renderer #(
    parameter int MODULE_COUNT = 4,
    parameter int DIGIT_COUNT  = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [ccr_pkg::BIN_W-1:0] i_number,
    input  wire logic [2:0]                i_first_position,
    input  wire logic [7:0]                i_last_position,
    input  wire logic                      i_leading_zeros,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [2:0]                     o_module_index,
    output logic [2:0]                     o_column_index,
    output logic [7:0]                     o_column_pattern,
    output logic                           o_last_column
);
    import ccr_pkg::*;

    localparam bit WIDE = (MODULE_COUNT > 3) && (DIGIT_COUNT >= 6);

    t_state     r_state;
    t_state     n_state;
    logic       r_op;
    logic       r_zeros;
    logic [2:0] r_top;
    logic [2:0] r_last;
    logic [2:0] r_place;
    logic [2:0] r_col;

    logic       r_out_valid;
    logic [2:0] r_module;
    logic [2:0] r_column;
    logic [7:0] r_pattern;
    logic       r_last_col;

    t_bcd_rsp   bcd_rsp;
    logic       bcd_start;
    logic       accept;
    logic       step;

    logic [7:0] last_res;
    logic [2:0] top_res;
    logic       range_ok;

    logic [2:0] k;
    logic [4:0] nz;
    logic       sig;
    t_digit     digit;
    logic [2:0] width_m1;
    logic [4:0] strip_col;
    logic [7:0] pattern;
    logic       is_last;

    ccr_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bcd_start),
        .i_number (i_number),
        .o_rsp    (bcd_rsp)
    );

    // Request decode: resolve the last place, clip to the big places on narrow strips and check the range.
    always_comb begin
        last_res = (i_last_position == LAST_SAME) ? {5'd0, i_first_position} : i_last_position;
        top_res  = (!WIDE && last_res[2:0] > BIG_TOP) ? BIG_TOP : last_res[2:0];
        range_ok = (last_res <= PLACE_MAX) && ({5'd0, i_first_position} <= last_res)
                   && (i_first_position <= top_res);
    end

    // Digit of the current place and its glyph column.
    always_comb begin
        k = r_last - r_place;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            nz[i] = (bcd_rsp.digits[i] != 4'd0);
        end
        case (k)
            3'd1:    sig = |nz[4:1];
            3'd2:    sig = |nz[4:2];
            3'd3:    sig = |nz[4:3];
            3'd4:    sig = nz[4];
            default: sig = 1'b0;
        endcase
        if (r_op) begin
            digit = DIGIT_BLANK;
        end else if (k == 3'd0) begin
            digit = bcd_rsp.digits[0];
        end else if (sig) begin
            digit = bcd_rsp.digits[k[2:0] < 3'd5 ? k : 3'd0];
        end else begin
            digit = r_zeros ? 4'd0 : DIGIT_BLANK;
        end
        width_m1  = (r_place < BIG_PLACES) ? BIG_W_M1 : SMALL_W_M1;
        strip_col = place_start(r_place) + {2'd0, r_col};
        pattern   = (r_place < BIG_PLACES) ? big_col(digit, r_col) : small_col(digit, r_col);
        is_last   = (r_place == r_top) && (r_col == width_m1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && range_ok) begin
                    n_state = i_operation ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                if (bcd_rsp.done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (step && is_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        bcd_start  = 1'b0;
        step       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                bcd_start  = i_in_valid && range_ok && !i_operation;
            end
            ST_CONV: begin
            end
            ST_EMIT: begin
                step = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_zeros <= i_leading_zeros;
            r_top   <= top_res;
            r_last  <= last_res[2:0];
            r_place <= i_first_position;
            r_col   <= 3'd0;
        end else if (step) begin
            if (r_col == width_m1) begin
                r_col   <= 3'd0;
                r_place <= r_place + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end
        if (step) begin
            r_module   <= {1'b0, strip_col[4:3]};
            r_column   <= ~strip_col[2:0];
            r_pattern  <= pattern;
            r_last_col <= is_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_module_index   = r_module;
    assign o_column_index   = r_column;
    assign o_column_pattern = r_pattern;
    assign o_last_column    = r_last_col;

endmodule

`default_nettype wire

FILE: dv/column_checker.sv
// Request codes and the checker that predicts and compares column writes of the renderer.
`timescale 1ns / 100ps

package clock_tb_pkg;

    typedef enum logic {
        OP_WRITE,
        OP_BLANK
    } t_op_code;

endpackage

module column_checker #(
    parameter int MODULE_COUNT = 4,
    parameter int DIGIT_COUNT  = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_number,
    input  logic [2:0]  i_first_position,
    input  logic [7:0]  i_last_position,
    input  logic        i_leading_zeros,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_module_index,
    input  logic [2:0]  i_column_index,
    input  logic [7:0]  i_column_pattern,
    input  logic        i_last_column,
    output int          o_fail_count,
    output int          o_pending
);

    import clock_tb_pkg::*;

    typedef struct packed {
        logic [2:0] module_index;
        logic [2:0] column_index;
        logic [7:0] pattern;
        logic       last_col;
    } t_column_write;

    localparam bit WIDE_STRIP = (MODULE_COUNT > 3) && (DIGIT_COUNT >= 6);
    localparam int NO_GLYPH   = 10;

    localparam int DECADE [6]          = '{1, 10, 100, 1000, 10000, 100000};
    localparam int PLACE_FIRST_COL [6] = '{0, 6, 13, 19, 25, 29};

    localparam logic [7:0] WIDE_FONT [50] = '{
        8'h7E, 8'hFF, 8'h81, 8'hFF, 8'h7E,
        8'h00, 8'h04, 8'hFE, 8'hFF, 8'h00,
        8'hC2, 8'hE1, 8'hB1, 8'h9F, 8'h8E,
        8'h49, 8'h8D, 8'h8F, 8'hFB, 8'h71,
        8'h38, 8'h24, 8'hFE, 8'hFF, 8'h20,
        8'h4F, 8'h8F, 8'h89, 8'hF9, 8'h71,
        8'h7E, 8'hFF, 8'h89, 8'hF9, 8'h70,
        8'h01, 8'hF1, 8'hF9, 8'h0F, 8'h07,
        8'h76, 8'hFF, 8'h89, 8'hFF, 8'h76,
        8'h0E, 8'h9F, 8'h91, 8'hFF, 8'h7E
    };

    localparam logic [7:0] NARROW_FONT [30] = '{
        8'hF8, 8'h88, 8'hF8,
        8'h10, 8'hF8, 8'h00,
        8'hE8, 8'hA8, 8'hB8,
        8'h88, 8'hA8, 8'hF8,
        8'h70, 8'h40, 8'hF8,
        8'hB8, 8'hA8, 8'hE8,
        8'hF8, 8'hA8, 8'hE8,
        8'h08, 8'h08, 8'hF8,
        8'hF8, 8'hA8, 8'hF8,
        8'hB8, 8'hA8, 8'hF8
    };

    t_column_write expected_columns[$];
    int            mismatch_count = 0;

    initial o_fail_count = 0;
    initial o_pending    = 0;

    // Appends the column writes that one accepted request should produce.
    function automatic void render_columns(input t_op_code op, input logic [15:0] value,
                                           input logic [2:0] first, input logic [7:0] last_in,
                                           input logic pad_zeros);
        logic [7:0]    last;
        int            top;
        int            k;
        int            digit;
        int            width;
        int            strip_col;
        t_column_write w;
        last = (last_in == ccr_pkg::LAST_SAME) ? {5'd0, first} : last_in;
        if (last > ccr_pkg::PLACE_MAX || {5'd0, first} > last) return;
        top = int'(last);
        if (!WIDE_STRIP && top > 3) top = 3;
        if (int'(first) > top) return;
        for (int p = int'(first); p <= top; p++) begin
            // Digits are right-aligned at the last place, so place p shows digit k.
            k = int'(last) - p;
            if (op == OP_BLANK) digit = NO_GLYPH;
            else if (k == 0 && value == 16'd0) digit = 0;
            else if (int'(value) >= DECADE[k]) digit = (int'(value) / DECADE[k]) % 10;
            else digit = pad_zeros ? 0 : NO_GLYPH;
            width = (p < 4) ? 5 : 3;
            for (int j = 0; j < width; j++) begin
                strip_col      = PLACE_FIRST_COL[p] + j;
                w.module_index = 3'(strip_col / 8);
                w.column_index = 3'(7 - strip_col % 8);
                if (digit == NO_GLYPH) w.pattern = 8'h00;
                else if (p < 4) w.pattern = WIDE_FONT[digit * 5 + j];
                else w.pattern = NARROW_FONT[digit * 3 + j];
                w.last_col = (p == top) && (j == width - 1);
                expected_columns.push_back(w);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_column_write want;
        if (i_rst_n) begin
            // Results are checked before the new request is predicted, so a column
            // cannot be matched against an expectation pushed on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_columns.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected column write: mod %0d col %0d pat %02h last %0b",
                                 i_module_index, i_column_index, i_column_pattern,
                                 i_last_column);
                end else begin
                    want = expected_columns.pop_front();
                    if (want.module_index != i_module_index ||
                        want.column_index != i_column_index ||
                        want.pattern != i_column_pattern ||
                        want.last_col != i_last_column) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("column mismatch: exp %0d/%0d/%02h/%0b got %0d/%0d/%02h/%0b",
                                     want.module_index, want.column_index, want.pattern,
                                     want.last_col, i_module_index, i_column_index,
                                     i_column_pattern, i_last_column);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                render_columns(t_op_code'(i_operation), i_number, i_first_position,
                               i_last_position, i_leading_zeros);
        end
        o_fail_count = mismatch_count;
        o_pending    = expected_columns.size();
    end

endmodule

FILE: dv/tb.sv
// Top of the renderer testbench: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;

    import clock_tb_pkg::*;

    localparam int MODULE_COUNT = 4;
    localparam int DIGIT_COUNT  = 6;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        operation  = 1'b0;
    logic [15:0] number     = 16'd0;
    logic [2:0]  first_pos  = 3'd0;
    logic [7:0]  last_pos   = 8'd0;
    logic        lead_zeros = 1'b0;
    logic        out_stall  = 1'b0;
    logic        idling_on  = 1'b1;
    int          quiet_cycles = 0;

    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [2:0] module_index;
    wire logic [2:0] column_index;
    wire logic [7:0] column_pattern;
    wire logic       last_column;
    int              fail_count;
    int              pending;

    clock_digit_column_renderer #(
        .MODULE_COUNT(MODULE_COUNT),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_operation     (operation),
        .i_number        (number),
        .i_first_position(first_pos),
        .i_last_position (last_pos),
        .i_leading_zeros (lead_zeros),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_module_index  (module_index),
        .o_column_index  (column_index),
        .o_column_pattern(column_pattern),
        .o_last_column   (last_column)
    );

    column_checker #(
        .MODULE_COUNT(MODULE_COUNT),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_operation     (operation),
        .i_number        (number),
        .i_first_position(first_pos),
        .i_last_position (last_pos),
        .i_leading_zeros (lead_zeros),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_module_index  (module_index),
        .i_column_index  (column_index),
        .i_column_pattern(column_pattern),
        .i_last_column   (last_column),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Presents one request at a falling edge and returns at the falling edge after
    // it is accepted, so back-to-back requests keep valid high.
    task automatic send_request(input t_op_code op, input logic [15:0] value,
                                input logic [2:0] first, input logic [7:0] last,
                                input logic pad);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        number     <= value;
        first_pos  <= first;
        last_pos   <= last;
        lead_zeros <= pad;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        forever begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0) repeat (20) @(negedge clk);
            end
        end
    end

    // Watchdog: a long stretch with neither channel moving means the block hung.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_op_code    op;
        logic [15:0] value;
        logic [2:0]  first;
        logic [7:0]  last;
        int          sel;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests: value extremes, both fonts, truncation, blanking, bad ranges.
        send_request(OP_WRITE, 16'd0,     3'd0, 8'd255, 1'b0);
        send_request(OP_WRITE, 16'd65535, 3'd0, 8'd5,   1'b1);
        send_request(OP_WRITE, 16'd65535, 3'd0, 8'd5,   1'b0);
        send_request(OP_WRITE, 16'd0,     3'd0, 8'd5,   1'b0);
        send_request(OP_WRITE, 16'd0,     3'd0, 8'd5,   1'b1);
        send_request(OP_WRITE, 16'd12345, 3'd1, 8'd5,   1'b0);
        send_request(OP_WRITE, 16'd9876,  3'd2, 8'd3,   1'b0);
        send_request(OP_WRITE, 16'd100,   3'd4, 8'd5,   1'b0);
        send_request(OP_WRITE, 16'd7,     3'd5, 8'd255, 1'b0);
        send_request(OP_WRITE, 16'd10000, 3'd0, 8'd5,   1'b0);
        send_request(OP_BLANK, 16'd0,     3'd0, 8'd5,   1'b0);
        send_request(OP_BLANK, 16'd65535, 3'd3, 8'd4,   1'b1);
        send_request(OP_WRITE, 16'd4321,  3'd0, 8'd3,   1'b1);
        send_request(OP_WRITE, 16'd42,    3'd3, 8'd2,   1'b1);
        send_request(OP_WRITE, 16'd42,    3'd0, 8'd6,   1'b1);
        send_request(OP_WRITE, 16'd42,    3'd2, 8'd254, 1'b0);
        send_request(OP_WRITE, 16'd3,     3'd6, 8'd255, 1'b1);
        send_request(OP_BLANK, 16'd3,     3'd7, 8'd255, 1'b0);
        send_request(OP_WRITE, 16'd55,    3'd4, 8'd4,   1'b0);
        send_request(OP_WRITE, 16'd1,     3'd5, 8'd5,   1'b1);
        send_request(OP_WRITE, 16'd9,     3'd7, 8'd128, 1'b1);
        send_request(OP_WRITE, 16'd32768, 3'd0, 8'd0,   1'b0);
        send_request(OP_WRITE, 16'd60000, 3'd1, 8'd5,   1'b1);
        send_request(OP_WRITE, 16'd5,     3'd0, 8'd0,   1'b1);

        // Random requests, mostly in range; the final stretch runs without any idling.
        for (int n = 0; n < 96; n++) begin
            if (n == 76) idling_on = 1'b0;
            op = ($urandom_range(0, 4) == 0) ? OP_BLANK : OP_WRITE;
            case ($urandom_range(0, 3))
                0:       value = 16'($urandom_range(0, 9));
                1:       value = 16'($urandom_range(0, 999));
                default: value = 16'($urandom_range(0, 65535));
            endcase
            first = 3'($urandom_range(0, 5));
            sel   = $urandom_range(0, 9);
            if (sel < 2) last = ccr_pkg::LAST_SAME;
            else if (sel < 9) last = 8'($urandom_range(int'(first), 5));
            else begin
                last = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) first = 3'($urandom_range(0, 7));
            end
            send_request(op, value, first, last, 1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
